// File: hw/rtl/lcms_pkg.sv
// ---------------------------------------------------------------------------
// lcms_pkg: shared types and constants
// Widths, function codes, register indexes and controller command struct
// for the min-max scaled linear classifier.
// ---------------------------------------------------------------------------
package lcms_pkg;

   localparam int MaxFeatures = 64;
   localparam int IdxW = 6;
   localparam int QuoW = 52;                  // |num*2^17| < 2^50, two guard bits
   localparam int DivSteps = QuoW;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   localparam logic [IdxW-1:0] REG_LABEL_NEG = 6'd0;
   localparam logic [IdxW-1:0] REG_LABEL_POS = 6'd1;

   // controller to datapath
   typedef struct packed {
      logic capture;     // latch the accepted item
      logic table_write; // write the table entry of a load
      logic div_start;   // set up the divider from the read entry
      logic div_step;    // one quotient bit
      logic mult;        // form norm and product
      logic accum;       // add term to the accumulator
      logic emit;        // load the result register and clear the sum
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_sample;
      logic is_last;
      logic degen;       // max equals min
   } dp_status_type;

endpackage

// File: hw/rtl/linear_classifier_minmax_scaled.sv
// ---------------------------------------------------------------------------
// linear_classifier_minmax_scaled: min-max scaled linear two-class classifier
// A load item is captured and then written to the tables. A sample item
// passes through the 52-step bit-serial divider that scales the feature,
// the multiplier and, unless its feature has equal max and min, the accumulator.
// One item is in work at a time. A result waits in the output register
// while the next item is taken; an item that ends a sample waits further
// while the previous result is still stalled. Labels are written on the
// csr port.
// ---------------------------------------------------------------------------
module linear_classifier_minmax_scaled (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_func,
   input  logic [5:0]         req_entry_index,
   input  logic signed [31:0] req_weight,
   input  logic signed [31:0] req_range_low,
   input  logic signed [31:0] req_range_high,
   input  logic signed [31:0] req_feature_value,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_label,
   output logic signed [63:0] rsp_score,
   output logic               rsp_degenerate,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [5:0]         csr_index,
   input  logic [15:0]        csr_data
);
   import lcms_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   lcms_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .cmd, .status
   );

   lcms_datapath u_dp (
      .clock, .reset, .cmd, .status,
      .req_func, .req_entry_index, .req_weight, .req_range_low,
      .req_range_high, .req_feature_value, .req_last,
      .csr_write(csr_valid), .csr_index, .csr_data,
      .out_label(rsp_label), .out_score(rsp_score),
      .out_degenerate(rsp_degenerate)
   );
endmodule

// File: hw/rtl/lcms_datapath.sv
// ---------------------------------------------------------------------------
// lcms_datapath: tables, divider, multiplier and accumulator
// Holds the feature tables, a restoring bit-serial divider for the scaling,
// a 32x32 multiplier stage, the saturating accumulator and label registers.
// ---------------------------------------------------------------------------
module lcms_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  lcms_pkg::dp_cmd_type     cmd,
   output lcms_pkg::dp_status_type  status,
   input  logic                     req_func,
   input  logic [5:0]               req_entry_index,
   input  logic signed [31:0]       req_weight,
   input  logic signed [31:0]       req_range_low,
   input  logic signed [31:0]       req_range_high,
   input  logic signed [31:0]       req_feature_value,
   input  logic                     req_last,
   input  logic                     csr_write,
   input  logic [5:0]               csr_index,
   input  logic [15:0]              csr_data,
   output logic signed [15:0]       out_label,
   output logic signed [63:0]       out_score,
   output logic                     out_degenerate
);
   import lcms_pkg::*;

   logic [31:0] weight_mem [MaxFeatures];
   logic [31:0] low_mem [MaxFeatures];
   logic [31:0] high_mem [MaxFeatures];

   logic              func_ff, last_ff;
   logic [IdxW-1:0]   idx_ff;
   logic signed [31:0] w_in_ff, lo_in_ff, hi_in_ff, v_ff;
   logic signed [31:0] rw_ff, rlo_ff, rhi_ff;

   logic [QuoW-1:0]   rem_ff, rem_in;
   logic [QuoW-1:0]   quo_ff, quo_in;
   logic [QuoW-1:0]   dvd_ff;
   logic [32:0]       dvs_ff;
   logic              neg_ff, degen_cur_ff;
   logic signed [63:0] term_ff;
   logic signed [63:0] acc_ff;
   logic              dseen_ff;
   logic [15:0]       lneg_ff, lpos_ff;
   logic signed [15:0] label_ff;
   logic signed [63:0] score_ff;
   logic              dout_ff;

   // capture item and read tables
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= req_func;
         last_ff  <= req_last;
         idx_ff   <= req_entry_index;
         w_in_ff  <= req_weight;
         lo_in_ff <= req_range_low;
         hi_in_ff <= req_range_high;
         v_ff     <= req_feature_value;
         rw_ff    <= weight_mem[req_entry_index];
         rlo_ff   <= low_mem[req_entry_index];
         rhi_ff   <= high_mem[req_entry_index];
      end
      if (cmd.table_write) begin
         weight_mem[idx_ff] <= w_in_ff;
         low_mem[idx_ff]    <= lo_in_ff;
         high_mem[idx_ff]   <= hi_in_ff;
      end
   end

   // divider setup operands
   logic signed [32:0] num_s, den_s;
   logic [32:0] num_a, den_a;
   assign num_s = 33'(v_ff) - 33'(rlo_ff);
   assign den_s = 33'(rhi_ff) - 33'(rlo_ff);
   assign num_a = num_s[32] ? 33'(-num_s) : num_s;
   assign den_a = den_s[32] ? 33'(-den_s) : den_s;

   assign status.is_sample = func_ff;
   assign status.is_last   = last_ff;
   assign status.degen     = degen_cur_ff;

   // one restoring step
   logic [QuoW:0] trial;
   always_comb begin
      trial  = {rem_ff, dvd_ff[QuoW-1]} - {{(QuoW-33+1){1'b0}}, dvs_ff};
      rem_in = trial[QuoW] ? {rem_ff[QuoW-2:0], dvd_ff[QuoW-1]} : trial[QuoW-1:0];
      quo_in = {quo_ff[QuoW-2:0], ~trial[QuoW]};
   end

   // norm with saturation
   logic signed [QuoW:0] q_s, norm_w;
   logic signed [31:0]   norm;
   always_comb begin
      q_s    = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      norm_w = q_s - (QuoW+1)'(65536);
      if (norm_w > (QuoW+1)'(64'sh7FFFFFFF)) norm = 32'sh7FFFFFFF;
      else if (norm_w < -(QuoW+1)'(64'sh80000000)) norm = 32'sh80000000;
      else norm = norm_w[31:0];
   end

   // saturating add
   logic signed [64:0] sum_w;
   logic signed [63:0] sum_sat;
   always_comb begin
      sum_w = 65'(acc_ff) + 65'(term_ff);
      if (sum_w[64] != sum_w[63]) sum_sat = sum_w[64] ? 64'sh8000000000000000
                                                      : 64'sh7FFFFFFFFFFFFFFF;
      else sum_sat = sum_w[63:0];
   end

   // divider and product registers
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         rem_ff <= '0;
         quo_ff <= '0;
         dvd_ff <= {{(QuoW-50){1'b0}}, num_a, 17'd0};
         dvs_ff <= den_a;
         neg_ff <= num_s[32] ^ den_s[32];
         degen_cur_ff <= (den_s == 33'sd0);
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         dvd_ff <= {dvd_ff[QuoW-2:0], 1'b0};
      end
      if (cmd.mult) term_ff <= 64'(rw_ff) * 64'(norm);
      // the sum is already complete in the accumulator
      if (cmd.emit) begin
         label_ff <= acc_ff[63] ? lneg_ff : lpos_ff;
         score_ff <= acc_ff;
         dout_ff  <= dseen_ff;
      end
   end

   // accumulator, flag and labels
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         dseen_ff <= 1'b0;
         lneg_ff  <= 16'd0;
         lpos_ff  <= 16'd1;
      end else begin
         if (csr_write && csr_index == REG_LABEL_NEG) lneg_ff <= csr_data;
         if (csr_write && csr_index == REG_LABEL_POS) lpos_ff <= csr_data;
         if (cmd.emit) begin
            acc_ff   <= '0;
            dseen_ff <= 1'b0;
         end else if (cmd.accum) begin
            acc_ff <= sum_sat;
         end else if (cmd.mult && degen_cur_ff) begin
            dseen_ff <= 1'b1;
         end
      end
   end

   assign out_label      = label_ff;
   assign out_score      = score_ff;
   assign out_degenerate = dout_ff;
endmodule

// File: hw/rtl/lcms_ctrl.sv
// ---------------------------------------------------------------------------
// lcms_ctrl: sequencing controller
// Accepts one item at a time, writes load items to the tables, and for samples
// steps the divider, multiplies, accumulates and hands a result to the output register.
// ---------------------------------------------------------------------------
module lcms_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output lcms_pkg::dp_cmd_type     cmd,
   input  lcms_pkg::dp_status_type  status
);
   import lcms_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0, S_DECODE = 3'd1, S_DIV = 3'd2,
                          S_MULT = 3'd3, S_ACC = 3'd4, S_EMIT = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic       rv_ff, rv_in;
   logic       degen_ok;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rv_ff;
   assign degen_ok  = status.degen;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rv_in    = rv_ff && rsp_stall;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (!status.is_sample) begin
               cmd.table_write = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.div_start = 1'b1;
               cnt_in = 6'(DivSteps - 1);
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) state_in = S_MULT;
         end
         S_MULT: begin
            cmd.mult = 1'b1;
            state_in = degen_ok ? (status.is_last ? S_EMIT : S_IDLE) : S_ACC;
         end
         S_ACC: begin
            cmd.accum = 1'b1;
            state_in = status.is_last ? S_EMIT : S_IDLE;
         end
         S_EMIT: begin
            if (!rv_ff || !rsp_stall) begin
               cmd.emit = 1'b1;
               rv_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rv_ff    <= rv_in;
      end
   end
endmodule
